### hdl/ccds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ccds_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 20;
    localparam int DIV_STEPS = WORD_BITS + FRAC_BITS;

    typedef logic signed [WORD_BITS-1:0] word_t;

    // register indexes
    localparam logic [2:0] REG_MASS      = 3'd0;
    localparam logic [2:0] REG_GRAVITY   = 3'd1;
    localparam logic [2:0] REG_RADIUS    = 3'd2;
    localparam logic [2:0] REG_DAMPING   = 3'd3;
    localparam logic [2:0] REG_STIFFNESS = 3'd4;
    localparam logic [2:0] REG_STEP      = 3'd5;

    localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    // saturating add
    function automatic word_t sadd(input word_t a, input word_t b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1])
            sadd = s[WORD_BITS] ? WMIN : WMAX;
        else
            sadd = s[WORD_BITS-1:0];
    endfunction

    // saturating negate
    function automatic word_t sneg(input word_t a);
        sneg = (a == WMIN) ? WMAX : -a;
    endfunction

    // saturating multiply, product truncated toward zero
    function automatic word_t smul(input word_t a, input word_t b);
        logic [WORD_BITS-1:0]   ua;
        logic [WORD_BITS-1:0]   ub;
        logic [2*WORD_BITS-1:0] p;
        logic [2*WORD_BITS-1:0] q;
        logic                   neg;
        ua  = a[WORD_BITS-1] ? WORD_BITS'(-a) : WORD_BITS'(a);
        ub  = b[WORD_BITS-1] ? WORD_BITS'(-b) : WORD_BITS'(b);
        neg = a[WORD_BITS-1] ^ b[WORD_BITS-1];
        p   = {{WORD_BITS{1'b0}}, ua} * {{WORD_BITS{1'b0}}, ub};
        q   = p >> FRAC_BITS;
        if (neg)
        begin
            if (q > {{WORD_BITS{1'b0}}, 1'b1, {(WORD_BITS-1){1'b0}}})
                smul = WMIN;
            else
                smul = word_t'(-q[WORD_BITS-1:0]);
        end
        else
        begin
            if (q > {{(WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}})
                smul = WMAX;
            else
                smul = word_t'(q[WORD_BITS-1:0]);
        end
    endfunction

endpackage
`default_nettype wire

### hdl/constrained_circle_dynamics_step.sv
`timescale 1ns / 1ps
`default_nettype none
// One semi-implicit Euler step of a point mass held to a circle by a
// Baumgarte-stabilized multiplier, in Q12.20. Fully pipelined: a beat may start
// every cycle; each result passes two chained dividers of
// WORD_BITS+FRAC_BITS+1 stages each plus thirteen arithmetic stages and
// shows for one cycle on done. The receiver cannot stall.
// Write configuration only while no beat is in flight.
module constrained_circle_dynamics_step
    import ccds_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire word_t       pos_x,
    input  wire word_t       pos_y,
    input  wire word_t       vel_x,
    input  wire word_t       vel_y,
    output logic             done,
    output word_t            next_pos_x,
    output word_t            next_pos_y,
    output word_t            next_vel_x,
    output word_t            next_vel_y,
    output word_t            constraint_residual,
    output logic             singular
);
    word_t m_reg, g_reg, r_reg, al_reg, be_reg, h_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg  <= word_t'(1048576);
            g_reg  <= word_t'(10286531);
            r_reg  <= word_t'(1048576);
            al_reg <= word_t'(10485760);
            be_reg <= word_t'(20971520);
            h_reg  <= word_t'(1049);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MASS:      m_reg  <= {1'b0, cfg_data[30:0]};
                REG_GRAVITY:   g_reg  <= cfg_data;
                REG_RADIUS:    r_reg  <= {1'b0, cfg_data[30:0]};
                REG_DAMPING:   al_reg <= {1'b0, cfg_data[30:0]};
                REG_STIFFNESS: be_reg <= {1'b0, cfg_data[30:0]};
                REG_STEP:      h_reg  <= {1'b0, cfg_data[30:0]};
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // item-independent terms, refreshed every cycle
    word_t rr_reg, mg_reg, bb_reg, a2_reg, nmg_reg;
    always_ff @(posedge clk)
    begin
        rr_reg  <= sneg(smul(r_reg, r_reg));
        mg_reg  <= smul(m_reg, g_reg);
        bb_reg  <= smul(be_reg, be_reg);
        a2_reg  <= sadd(al_reg, al_reg);
        nmg_reg <= sneg(smul(m_reg, g_reg));
    end

    logic [4:0] v_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[3:0], start};
    end

    // stage 1: products of the inputs
    word_t x1, y1, vx1, vy1, tx1, ty1, p1a, p1b, p1c, p1d, p1e, p1f;
    always_ff @(posedge clk)
    begin
        x1  <= pos_x;
        y1  <= pos_y;
        vx1 <= vel_x;
        vy1 <= vel_y;
        tx1 <= sadd(pos_x, pos_x);
        ty1 <= sadd(pos_y, pos_y);
        p1a <= smul(sadd(pos_x, pos_x), vel_x);
        p1b <= smul(sadd(pos_y, pos_y), vel_y);
        p1c <= smul(vel_x, vel_x);
        p1d <= smul(vel_y, vel_y);
        p1e <= smul(pos_x, pos_x);
        p1f <= smul(pos_y, pos_y);
    end

    // stage 2: jv, jdv, phi, den terms
    word_t x2, y2, vx2, vy2, tx2, ty2, jv2, jdv2, phi2, dx2, dy2;
    always_ff @(posedge clk)
    begin
        x2   <= x1;
        y2   <= y1;
        vx2  <= vx1;
        vy2  <= vy1;
        tx2  <= tx1;
        ty2  <= ty1;
        jv2  <= sadd(p1a, p1b);
        jdv2 <= sadd(sadd(p1c, p1d), sadd(p1c, p1d));
        phi2 <= sadd(sadd(p1e, p1f), rr_reg);
        dx2  <= smul(tx1, tx1);
        dy2  <= smul(ty1, ty1);
    end

    // stage 3: damping, stiffness and gravity products, den sum
    word_t x3, y3, vx3, vy3, tx3, ty3, c3a, c3b, c3c, den3, tmg3;
    always_ff @(posedge clk)
    begin
        x3   <= x2;
        y3   <= y2;
        vx3  <= vx2;
        vy3  <= vy2;
        tx3  <= tx2;
        ty3  <= ty2;
        c3a  <= sneg(jdv2);
        c3b  <= sneg(smul(a2_reg, jv2));
        c3c  <= sneg(smul(bb_reg, phi2));
        den3 <= sadd(dx2, dy2);
        tmg3 <= sneg(smul(ty2, mg_reg));
    end

    // stage 4: rhs c
    word_t x4, y4, vx4, vy4, tx4, ty4, c4, den4, tmg4;
    always_ff @(posedge clk)
    begin
        x4   <= x3;
        y4   <= y3;
        vx4  <= vx3;
        vy4  <= vy3;
        tx4  <= tx3;
        ty4  <= ty3;
        c4   <= sadd(sadd(c3a, c3b), c3c);
        den4 <= den3;
        tmg4 <= tmg3;
    end

    // stage 5: numerator
    word_t num5, den5;
    always_ff @(posedge clk)
    begin
        num5 <= sadd(tmg4, sneg(smul(m_reg, c4)));
        den5 <= den4;
    end

    // side pipe carrying the state across the lambda divider
    localparam int SD = DIV_STEPS + 1;
    word_t sx [SD+1], sy [SD+1], svx [SD+1], svy [SD+1], stx [SD+1], sty [SD+1];
    always_ff @(posedge clk)
    begin
        sx[0]  <= x4;
        sy[0]  <= y4;
        svx[0] <= vx4;
        svy[0] <= vy4;
        stx[0] <= tx4;
        sty[0] <= ty4;
        for (int i = 0; i < SD; i++)
        begin
            sx[i+1]  <= sx[i];
            sy[i+1]  <= sy[i];
            svx[i+1] <= svx[i];
            svy[i+1] <= svy[i];
            stx[i+1] <= stx[i];
            sty[i+1] <= sty[i];
        end
    end

    // lambda divide
    logic  lv6;
    word_t lq6;
    logic  sing_in;
    assign sing_in = (den5 == '0);
    ccds_div u_div_lam (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v_reg[4]),
        .num      (num5),
        .den      (sing_in ? word_t'(1) : den5),
        .out_valid(lv6),
        .quo      (lq6)
    );
    logic [DIV_STEPS:0] sg;
    always_ff @(posedge clk)
    begin
        sg <= {sg[DIV_STEPS-1:0], sing_in};
    end

    // stage 7: lambda products
    word_t x7, y7, vx7, vy7, ax7, ay7;
    logic  v7, s7;
    word_t lam6;
    assign lam6 = sg[DIV_STEPS] ? '0 : lq6;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v7 <= 1'b0;
        else
            v7 <= lv6;
    end
    always_ff @(posedge clk)
    begin
        x7  <= sx[SD];
        y7  <= sy[SD];
        vx7 <= svx[SD];
        vy7 <= svy[SD];
        s7  <= sg[DIV_STEPS];
        ax7 <= sneg(smul(stx[SD], lam6));
        ay7 <= sneg(smul(sty[SD], lam6));
    end

    // stage 8: y force sum
    word_t x8, y8, vx8, vy8, fx8, fy8;
    logic  v8, s8;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v8 <= 1'b0;
        else
            v8 <= v7;
    end
    always_ff @(posedge clk)
    begin
        x8  <= x7;
        y8  <= y7;
        vx8 <= vx7;
        vy8 <= vy7;
        s8  <= s7;
        fx8 <= ax7;
        fy8 <= sadd(nmg_reg, ay7);
    end

    // acceleration divides by mass
    logic  av, avy;
    word_t axq, ayq;
    ccds_div u_div_ax (
        .clk(clk), .rst_n(rst_n), .in_valid(v8), .num(fx8), .den(m_reg),
        .out_valid(av), .quo(axq)
    );
    ccds_div u_div_ay (
        .clk(clk), .rst_n(rst_n), .in_valid(v8), .num(fy8), .den(m_reg),
        .out_valid(avy), .quo(ayq)
    );
    word_t tx_ [SD+1], ty_ [SD+1], tvx [SD+1], tvy [SD+1];
    logic  ts [SD+1];
    always_ff @(posedge clk)
    begin
        tx_[0] <= x8;
        ty_[0] <= y8;
        tvx[0] <= vx8;
        tvy[0] <= vy8;
        ts[0]  <= s8;
        for (int i = 0; i < SD; i++)
        begin
            tx_[i+1] <= tx_[i];
            ty_[i+1] <= ty_[i];
            tvx[i+1] <= tvx[i];
            tvy[i+1] <= tvy[i];
            ts[i+1]  <= ts[i];
        end
    end

    // stage 9: h*a
    word_t x9, y9, vx9, vy9, hx9, hy9;
    logic  v9, s9;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v9 <= 1'b0;
        else
            v9 <= av;
    end
    always_ff @(posedge clk)
    begin
        x9  <= tx_[SD-1];
        y9  <= ty_[SD-1];
        vx9 <= tvx[SD-1];
        vy9 <= tvy[SD-1];
        s9  <= ts[SD-1];
        hx9 <= smul(h_reg, axq);
        hy9 <= smul(h_reg, ayq);
    end

    // stage 10: new velocity
    word_t x10, y10, nvx10, nvy10;
    logic  v10, s10;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v10 <= 1'b0;
        else
            v10 <= v9;
    end
    always_ff @(posedge clk)
    begin
        x10   <= x9;
        y10   <= y9;
        s10   <= s9;
        nvx10 <= sadd(vx9, hx9);
        nvy10 <= sadd(vy9, hy9);
    end

    // stage 11: h*v'
    word_t x11, y11, nvx11, nvy11, px11, py11;
    logic  v11, s11;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v11 <= 1'b0;
        else
            v11 <= v10;
    end
    always_ff @(posedge clk)
    begin
        x11   <= x10;
        y11   <= y10;
        s11   <= s10;
        nvx11 <= nvx10;
        nvy11 <= nvy10;
        px11  <= smul(h_reg, nvx10);
        py11  <= smul(h_reg, nvy10);
    end

    // stage 12: new position
    word_t nx12, ny12, nvx12, nvy12;
    logic  v12, s12;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v12 <= 1'b0;
        else
            v12 <= v11;
    end
    always_ff @(posedge clk)
    begin
        s12   <= s11;
        nvx12 <= nvx11;
        nvy12 <= nvy11;
        nx12  <= sadd(x11, px11);
        ny12  <= sadd(y11, py11);
    end

    // stage 13: squares
    word_t nx13, ny13, nvx13, nvy13, qx13, qy13;
    logic  v13, s13;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v13 <= 1'b0;
        else
            v13 <= v12;
    end
    always_ff @(posedge clk)
    begin
        s13   <= s12;
        nvx13 <= nvx12;
        nvy13 <= nvy12;
        nx13  <= nx12;
        ny13  <= ny12;
        qx13  <= smul(nx12, nx12);
        qy13  <= smul(ny12, ny12);
    end

    // stage 14: residual and output register
    logic done_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v13;
    end
    always_ff @(posedge clk)
    begin
        next_pos_x          <= nx13;
        next_pos_y          <= ny13;
        next_vel_x          <= nvx13;
        next_vel_y          <= nvy13;
        constraint_residual <= sadd(sadd(qx13, qy13), rr_reg);
        singular            <= s13;
    end
    assign done = done_reg;

    // checks
    a_div_align: assert property (@(posedge clk) disable iff (!rst_n) av == avy)
        else $error("mass dividers out of step");
    a_lam_to_acc: assert property (@(posedge clk) disable iff (!rst_n)
        av |-> $past(v8, DIV_STEPS + 1))
        else $error("acceleration beat without lambda beat");
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(av, 6))
        else $error("result without source beat");
endmodule
`default_nettype wire

### hdl/ccds_div.sv
`timescale 1ns / 1ps
`default_nettype none
// pipelined restoring divider, one quotient bit per stage, (a << FRAC) / b saturated
module ccds_div
    import ccds_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire word_t num,
    input  wire word_t den,
    output logic       out_valid,
    output word_t      quo
);
    localparam int NB = WORD_BITS + FRAC_BITS;

    logic [NB-1:0]        n_reg   [DIV_STEPS+1];
    logic [WORD_BITS-1:0] d_reg   [DIV_STEPS+1];
    logic [WORD_BITS:0]   r_reg   [DIV_STEPS+1];
    logic [NB-1:0]        q_reg   [DIV_STEPS+1];
    logic                 neg_reg [DIV_STEPS+1];
    logic                 z_reg   [DIV_STEPS+1];
    logic                 zn_reg  [DIV_STEPS+1];
    logic [DIV_STEPS:0]   v_reg;

    logic [WORD_BITS-1:0] un;
    logic [WORD_BITS-1:0] ud;
    assign un = num[WORD_BITS-1] ? WORD_BITS'(-num) : WORD_BITS'(num);
    assign ud = den[WORD_BITS-1] ? WORD_BITS'(-den) : WORD_BITS'(den);

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[DIV_STEPS-1:0], in_valid};
    end

    // entry stage
    always_ff @(posedge clk)
    begin
        n_reg[0]   <= {un, {FRAC_BITS{1'b0}}};
        d_reg[0]   <= ud;
        r_reg[0]   <= '0;
        q_reg[0]   <= '0;
        neg_reg[0] <= num[WORD_BITS-1] ^ den[WORD_BITS-1];
        z_reg[0]   <= (den == '0);
        zn_reg[0]  <= (num == '0);
    end

    // one quotient bit per stage
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_step
        logic [WORD_BITS:0] rs;
        assign rs = {r_reg[i][WORD_BITS-1:0], n_reg[i][NB-1-i]};
        always_ff @(posedge clk)
        begin
            n_reg[i+1]   <= n_reg[i];
            d_reg[i+1]   <= d_reg[i];
            neg_reg[i+1] <= neg_reg[i];
            z_reg[i+1]   <= z_reg[i];
            zn_reg[i+1]  <= zn_reg[i];
            if (rs >= {1'b0, d_reg[i]})
            begin
                r_reg[i+1] <= rs - {1'b0, d_reg[i]};
                q_reg[i+1] <= q_reg[i] | (NB'(1) << (NB-1-i));
            end
            else
            begin
                r_reg[i+1] <= rs;
                q_reg[i+1] <= q_reg[i];
            end
        end
    end

    // saturate result
    always_comb
    begin
        out_valid = v_reg[DIV_STEPS];
        if (z_reg[DIV_STEPS])
            quo = zn_reg[DIV_STEPS] ? '0 : (neg_reg[DIV_STEPS] ? WMIN : WMAX);
        else if (neg_reg[DIV_STEPS])
            quo = (q_reg[DIV_STEPS] > NB'({1'b1, {(WORD_BITS-1){1'b0}}})) ? WMIN :
                  word_t'(-q_reg[DIV_STEPS][WORD_BITS-1:0]);
        else
            quo = (q_reg[DIV_STEPS] > NB'(WMAX)) ? WMAX :
                  word_t'(q_reg[DIV_STEPS][WORD_BITS-1:0]);
    end
endmodule
`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import ccds_pkg::*;

    localparam int LATENCY    = 119;
    localparam int STALL_MAX  = 4000;

    typedef struct packed {
        word_t px;
        word_t py;
        word_t vx;
        word_t vy;
    } body_state_t;

    typedef struct packed {
        word_t nx;
        word_t ny;
        word_t nvx;
        word_t nvy;
        word_t res;
        logic  sing;
    } step_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        start;
    logic        busy;
    word_t       pos_x, pos_y, vel_x, vel_y;
    logic        done;
    word_t       next_pos_x, next_pos_y, next_vel_x, next_vel_y, constraint_residual;
    logic        singular;

    constrained_circle_dynamics_step u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .start(start), .busy(busy),
        .pos_x(pos_x), .pos_y(pos_y), .vel_x(vel_x), .vel_y(vel_y),
        .done(done),
        .next_pos_x(next_pos_x), .next_pos_y(next_pos_y),
        .next_vel_x(next_vel_x), .next_vel_y(next_vel_y),
        .constraint_residual(constraint_residual), .singular(singular)
    );

    // predictor copy of the registers
    logic [31:0] mass_q, gravity_q, radius_q, alpha_q, beta_q, step_q;

    body_state_t  pending_beats[$];
    step_result_t expected_steps[$];
    int           error_count;
    int           idle_pct;
    int           stall_cycles;
    logic         stim_done;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // fixed-point helpers, written independently of the rtl package
    function automatic word_t fx_sat(input logic signed [127:0] v);
        if (v > 128'sd2147483647)
            fx_sat = 32'h7fffffff;
        else if (v < -128'sd2147483648)
            fx_sat = 32'h80000000;
        else
            fx_sat = v[31:0];
    endfunction

    function automatic word_t fx_add(input word_t a, input word_t b);
        logic signed [127:0] s;
        s = 128'(a) + 128'(b);
        fx_add = fx_sat(s);
    endfunction

    function automatic word_t fx_neg(input word_t a);
        logic signed [127:0] s;
        s = -128'(a);
        fx_neg = fx_sat(s);
    endfunction

    function automatic word_t fx_mul(input word_t a, input word_t b);
        logic signed [127:0] p;
        logic [127:0]        m;
        p = 128'(a) * 128'(b);
        m = p < 0 ? -p : p;
        m = m >> FRAC_BITS;
        fx_mul = fx_sat(p < 0 ? -$signed(m) : $signed(m));
    endfunction

    function automatic word_t fx_div(input word_t a, input word_t b);
        logic signed [127:0] n;
        logic signed [127:0] d;
        logic [127:0]        q;
        if (b == 0)
            fx_div = (a == 0) ? 32'sd0 : (a > 0 ? 32'h7fffffff : 32'h80000000);
        else
        begin
            n = 128'(a);
            d = 128'(b);
            q = (n < 0 ? -n : n) << FRAC_BITS;
            q = q / (d < 0 ? -d : d);
            fx_div = fx_sat(((n < 0) != (d < 0)) ? -$signed(q) : $signed(q));
        end
    endfunction

    function automatic step_result_t predict_step(input body_state_t s);
        word_t m, g, r, al, be, h;
        word_t tx, ty, jv, jdv, rr, phi, c, mg, num, den, lam, ax, ay;
        word_t nvx, nvy, nx, ny;
        step_result_t o;
        m  = mass_q;
        g  = gravity_q;
        r  = radius_q;
        al = alpha_q;
        be = beta_q;
        h  = step_q;
        tx  = fx_add(s.px, s.px);
        ty  = fx_add(s.py, s.py);
        jv  = fx_add(fx_mul(tx, s.vx), fx_mul(ty, s.vy));
        jdv = fx_add(fx_mul(s.vx, s.vx), fx_mul(s.vy, s.vy));
        jdv = fx_add(jdv, jdv);
        rr  = fx_mul(r, r);
        phi = fx_add(fx_add(fx_mul(s.px, s.px), fx_mul(s.py, s.py)), fx_neg(rr));
        c   = fx_neg(jdv);
        c   = fx_add(c, fx_neg(fx_mul(fx_add(al, al), jv)));
        c   = fx_add(c, fx_neg(fx_mul(fx_mul(be, be), phi)));
        mg  = fx_mul(m, g);
        num = fx_add(fx_neg(fx_mul(ty, mg)), fx_neg(fx_mul(m, c)));
        den = fx_add(fx_mul(tx, tx), fx_mul(ty, ty));
        o.sing = (den == 0);
        lam = o.sing ? 32'sd0 : fx_div(num, den);
        ax  = fx_div(fx_neg(fx_mul(tx, lam)), m);
        ay  = fx_div(fx_add(fx_neg(mg), fx_neg(fx_mul(ty, lam))), m);
        nvx = fx_add(s.vx, fx_mul(h, ax));
        nvy = fx_add(s.vy, fx_mul(h, ay));
        nx  = fx_add(s.px, fx_mul(h, nvx));
        ny  = fx_add(s.py, fx_mul(h, nvy));
        o.nx  = nx;
        o.ny  = ny;
        o.nvx = nvx;
        o.nvy = nvy;
        o.res = fx_add(fx_add(fx_mul(nx, nx), fx_mul(ny, ny)), fx_neg(rr));
        predict_step = o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // driver: one beat per accepted start
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            pos_x <= '0;
            pos_y <= '0;
            vel_x <= '0;
            vel_y <= '0;
        end
        else
        begin
            if (start && !busy)
                expected_steps.push_back(predict_step({pos_x, pos_y, vel_x, vel_y}));
            if ((!start || !busy) && pending_beats.size() > 0
                && $urandom_range(99, 0) >= idle_pct)
            begin
                body_state_t b;
                b = pending_beats.pop_front();
                start <= 1'b1;
                pos_x <= b.px;
                pos_y <= b.py;
                vel_x <= b.vx;
                vel_y <= b.vy;
            end
            else if (!start || !busy)
                start <= 1'b0;
        end
    end

    // monitor: compare each done beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_steps.size() == 0)
            begin
                $display("unexpected result beat at %0t", $realtime);
                error_count++;
            end
            else
            begin
                step_result_t e;
                e = expected_steps.pop_front();
                if (next_pos_x !== e.nx) report_mismatch("next_pos_x", next_pos_x, e.nx);
                if (next_pos_y !== e.ny) report_mismatch("next_pos_y", next_pos_y, e.ny);
                if (next_vel_x !== e.nvx) report_mismatch("next_vel_x", next_vel_x, e.nvx);
                if (next_vel_y !== e.nvy) report_mismatch("next_vel_y", next_vel_y, e.nvy);
                if (constraint_residual !== e.res)
                    report_mismatch("constraint_residual", constraint_residual, e.res);
                if (singular !== e.sing) report_mismatch("singular", singular, e.sing);
            end
        end
    end

    // watchdog on cycles with no accepted beat and no result
    always @(posedge clk)
    begin
        if ((start && !busy) || done || pending_beats.size() == 0 && expected_steps.size() == 0)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_MASS:      mass_q    <= {1'b0, val[30:0]};
            REG_GRAVITY:   gravity_q <= val;
            REG_RADIUS:    radius_q  <= {1'b0, val[30:0]};
            REG_DAMPING:   alpha_q   <= {1'b0, val[30:0]};
            REG_STIFFNESS: beta_q    <= {1'b0, val[30:0]};
            REG_STEP:      step_q    <= {1'b0, val[30:0]};
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_beats.size() > 0 || expected_steps.size() > 0 || start)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    function automatic word_t rand_word();
        case ($urandom_range(5, 0))
            0: rand_word = $urandom;
            1: rand_word = $signed($urandom_range(2097152, 0)) - 32'sd1048576;
            2: rand_word = $signed($urandom_range(65535, 0)) - 32'sd32768;
            3: rand_word = $urandom_range(1, 0) ? 32'h7fffffff : 32'h80000000;
            default: rand_word = $signed($urandom_range(8388608, 0)) - 32'sd4194304;
        endcase
    endfunction

    // positions in the square around the unit circle, moderate velocity: the normal operating case
    function automatic body_state_t orbit_beat();
        body_state_t b;
        b.px = $signed($urandom_range(2200000, 0)) - 32'sd1100000;
        b.py = $signed($urandom_range(2200000, 0)) - 32'sd1100000;
        b.vx = $signed($urandom_range(8000000, 0)) - 32'sd4000000;
        b.vy = $signed($urandom_range(8000000, 0)) - 32'sd4000000;
        orbit_beat = b;
    endfunction

    task automatic queue_random(input int n);
        body_state_t b;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99, 0) < 65)
                b = orbit_beat();
            else
                b = {rand_word(), rand_word(), rand_word(), rand_word()};
            pending_beats.push_back(b);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        error_count = 0;
        idle_pct    = 19;
        stall_cycles = 0;
        mass_q    = 32'd1048576;
        gravity_q = 32'd10286531;
        radius_q  = 32'd1048576;
        alpha_q   = 32'd10485760;
        beta_q    = 32'd20971520;
        step_q    = 32'd1049;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: origin, tiny offsets, field extremes, on the circle
        pending_beats.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd0});
        pending_beats.push_back({32'sd0, 32'sd0, 32'sd1048576, -32'sd1048576});
        pending_beats.push_back({32'sd1, 32'sd0, 32'sd0, 32'sd0});
        pending_beats.push_back({32'sd0, -32'sd1, 32'sd5, 32'sd0});
        pending_beats.push_back({32'sd300, 32'sd300, 32'sd0, 32'sd0});
        pending_beats.push_back({32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
        pending_beats.push_back({32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000});
        pending_beats.push_back({32'h7fffffff, 32'h80000000, 32'sd0, 32'hffffffff});
        pending_beats.push_back({32'sd1048576, 32'sd0, 32'sd0, 32'sd1048576});
        pending_beats.push_back({32'sd0, -32'sd1048576, 32'sd2097152, 32'sd0});
        pending_beats.push_back({32'sd741455, 32'sd741455, -32'sd741455, 32'sd741455});
        pending_beats.push_back({32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff});
        wait_drained();

        // mass zero and a non-register index
        write_reg(REG_MASS, 32'd0);
        write_reg(3'd7, 32'hdeadbeef);
        pending_beats.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd0});
        pending_beats.push_back({32'sd1048576, 32'sd0, 32'sd0, 32'sd1048576});
        pending_beats.push_back({32'sd0, -32'sd1048576, 32'sd0, 32'sd0});
        wait_drained();

        // phase 1: default settings
        write_reg(REG_MASS, 32'd1048576);
        queue_random(450);
        wait_drained();

        // phase 2: extremes, sender idle heavily
        idle_pct = 51;
        write_reg(REG_MASS, 32'h7fffffff);
        write_reg(REG_GRAVITY, 32'h80000000);
        write_reg(REG_RADIUS, 32'h7fffffff);
        write_reg(REG_DAMPING, 32'h7fffffff);
        write_reg(REG_STIFFNESS, 32'h7fffffff);
        write_reg(REG_STEP, 32'h7fffffff);
        queue_random(300);
        wait_drained();

        // phase 3: small values and maximum gravity, top bit of mass set to check masking, no idling
        idle_pct = 0;
        write_reg(REG_MASS, 32'h80000001);
        write_reg(REG_GRAVITY, 32'h7fffffff);
        write_reg(REG_RADIUS, 32'd0);
        write_reg(REG_DAMPING, 32'd0);
        write_reg(REG_STIFFNESS, 32'd0);
        write_reg(REG_STEP, 32'd0);
        queue_random(250);
        wait_drained();

        // phase 4: random settings, mostly in a physical range, gravity unrestricted
        for (int k = 0; k < 4; k++)
        begin
            write_reg(REG_MASS, $urandom_range(8388608, 1));
            write_reg(REG_GRAVITY, $urandom);
            write_reg(REG_RADIUS, $urandom_range(4194304, 0));
            write_reg(REG_DAMPING, $urandom_range(31457280, 0));
            write_reg(REG_STIFFNESS, $urandom_range(31457280, 0));
            write_reg(REG_STEP, $urandom_range(104857, 0));
            queue_random(210);
            wait_drained();
        end

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
